// ===== design/fra_pkg.sv =====
// Package for the fraction arithmetic block with trial-division reduction.
// Holds the field widths, action codes and the command and status structs.
// Used by every module in the design folder; depends on nothing.
package fra_pkg;

    localparam int DATA_W = 16;
    localparam int ACT_W  = 3;
    localparam int PROD_W = 32;
    localparam int MAG_W  = 32;
    localparam int NUM_W  = 32;
    localparam int DEN_W  = 31;
    localparam int ACC_W  = 31;

    localparam logic [ACT_W-1:0] ACT_ADD   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SUB   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MUL   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DIV   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

    localparam logic [ACC_W-1:0] ACC_ONE = 31'd1;
    localparam logic [ACC_W-1:0] ACC_MAX = 31'h7FFF_FFFF;
    localparam logic [NUM_W-1:0] NUM_MAX = 32'h7FFF_FFFF;
    localparam logic [DEN_W-1:0] DEN_MAX = 31'h3FFF_FFFF;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic form;
        logic div_step;
        logic apply;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

// ===== design/fra_div_lane.sv =====
// One lane of the bit-serial restoring divider: quotient and remainder of a
// 32-bit magnitude by a small divisor, one quotient bit per cycle with i_step.
// Depends on fra_pkg.
module fra_div_lane #(
    parameter int KW = 10
) (
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic [fra_pkg::MAG_W-1:0] i_dividend,
    input  logic                     i_step,
    input  logic [KW-1:0]            i_divisor,
    output logic [fra_pkg::MAG_W-1:0] o_quot,
    output logic [KW-1:0]            o_rem
);

    logic [fra_pkg::MAG_W-1:0] r_q;
    logic [KW-1:0]             r_r;
    logic [KW:0]               n_trial;
    logic                      n_fit;
    logic [KW:0]               n_diff;

    assign n_trial = {r_r, r_q[fra_pkg::MAG_W-1]};
    assign n_fit   = n_trial >= {1'b0, i_divisor};
    assign n_diff  = n_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_dividend;
            r_r <= '0;
        end else if (i_step) begin
            r_q <= {r_q[fra_pkg::MAG_W-2:0], n_fit};
            r_r <= n_fit ? n_diff[KW-1:0] : n_trial[KW-1:0];
        end
    end

    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

// ===== design/fra_datapath.sv =====
// Datapath: operand and cross-product registers, the two divider lanes,
// the trial divisor, the saturating divisor product and the output register.
// Depends on fra_pkg and fra_div_lane.
module fra_datapath #(
    parameter int REDUCE_STEPS = 500
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fra_pkg::t_cmd                      i_cmd,
    output fra_pkg::t_sts                      o_sts,
    input  logic [fra_pkg::ACT_W-1:0]          i_action,
    input  logic signed [fra_pkg::DATA_W-1:0]  i_a_num,
    input  logic signed [fra_pkg::DATA_W-1:0]  i_a_den,
    input  logic signed [fra_pkg::DATA_W-1:0]  i_b_num,
    input  logic signed [fra_pkg::DATA_W-1:0]  i_b_den,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic signed [fra_pkg::NUM_W-1:0]   o_result_num,
    output logic signed [fra_pkg::DEN_W-1:0]   o_result_den,
    output logic [fra_pkg::ACC_W-1:0]          o_divisor_product
);

    localparam int KW = $clog2(REDUCE_STEPS + 3);
    localparam int PW = fra_pkg::ACC_W + KW;

    logic [fra_pkg::ACT_W-1:0]          r_act;
    logic signed [fra_pkg::DATA_W-1:0]  r_an, r_ad, r_bn, r_bd;
    logic signed [fra_pkg::PROD_W-1:0]  r_p1, r_p2, r_p3;
    logic                               r_nneg, r_dneg;
    logic [fra_pkg::MAG_W-1:0]          r_nm, r_dm;
    logic [KW-1:0]                      r_k;
    logic [fra_pkg::ACC_W-1:0]          r_acc;
    logic [PW-1:0]                      r_prod;
    logic                               r_prod_vld;
    logic                               r_o_valid;
    logic signed [fra_pkg::NUM_W-1:0]   r_res_num;
    logic signed [fra_pkg::DEN_W-1:0]   r_res_den;
    logic [fra_pkg::ACC_W-1:0]          r_res_prod;

    logic signed [fra_pkg::DATA_W-1:0]  n_op1, n_op3;
    logic signed [fra_pkg::PROD_W-1:0]  n_p1, n_p2, n_p3;
    logic signed [fra_pkg::PROD_W:0]    n_num, n_den;
    logic [fra_pkg::PROD_W:0]           n_nabs, n_dabs;
    logic [fra_pkg::MAG_W-1:0]          n_nq, n_dq;
    logic [KW-1:0]                      n_nrem, n_drem;
    logic                               n_divisible;
    logic                               n_lane_load;
    logic [fra_pkg::MAG_W-1:0]          n_ndvd, n_ddvd;
    logic [fra_pkg::ACC_W-1:0]          n_acc_sat;
    logic [fra_pkg::MAG_W:0]            n_nneg_val;
    logic [fra_pkg::MAG_W-1:0]          n_dneg_val;
    logic signed [fra_pkg::NUM_W-1:0]   n_res_num;
    logic signed [fra_pkg::DEN_W-1:0]   n_res_den;

    assign n_op1 = (r_act == fra_pkg::ACT_MUL) ? r_bn : r_bd;
    assign n_op3 = (r_act == fra_pkg::ACT_DIV) ? r_bn : r_bd;
    assign n_p1  = fra_pkg::PROD_W'(r_an) * fra_pkg::PROD_W'(n_op1);
    assign n_p2  = fra_pkg::PROD_W'(r_bn) * fra_pkg::PROD_W'(r_ad);
    assign n_p3  = fra_pkg::PROD_W'(r_ad) * fra_pkg::PROD_W'(n_op3);

    always_comb begin
        case (r_act)
            fra_pkg::ACT_ADD: n_num = {r_p1[fra_pkg::PROD_W-1], r_p1}
                                    + {r_p2[fra_pkg::PROD_W-1], r_p2};
            fra_pkg::ACT_SUB: n_num = {r_p1[fra_pkg::PROD_W-1], r_p1}
                                    - {r_p2[fra_pkg::PROD_W-1], r_p2};
            default:          n_num = {r_p1[fra_pkg::PROD_W-1], r_p1};
        endcase
    end

    assign n_den  = {r_p3[fra_pkg::PROD_W-1], r_p3};
    assign n_nabs = n_num[fra_pkg::PROD_W] ? -n_num : n_num;
    assign n_dabs = n_den[fra_pkg::PROD_W] ? -n_den : n_den;

    fra_div_lane #(.KW(KW)) u_num_lane (
        .i_clk      (i_clk),
        .i_load     (n_lane_load),
        .i_dividend (n_ndvd),
        .i_step     (i_cmd.div_step),
        .i_divisor  (r_k),
        .o_quot     (n_nq),
        .o_rem      (n_nrem)
    );

    fra_div_lane #(.KW(KW)) u_den_lane (
        .i_clk      (i_clk),
        .i_load     (n_lane_load),
        .i_dividend (n_ddvd),
        .i_step     (i_cmd.div_step),
        .i_divisor  (r_k),
        .o_quot     (n_dq),
        .o_rem      (n_drem)
    );

    assign n_divisible = (n_nrem == '0) && (n_drem == '0);
    assign n_lane_load = i_cmd.form || i_cmd.apply;
    assign n_ndvd = i_cmd.form ? n_nabs[fra_pkg::MAG_W-1:0] : (n_divisible ? n_nq : r_nm);
    assign n_ddvd = i_cmd.form ? n_dabs[fra_pkg::MAG_W-1:0] : (n_divisible ? n_dq : r_dm);

    assign n_acc_sat = (|r_prod[PW-1:fra_pkg::ACC_W]) ? fra_pkg::ACC_MAX
                                                     : r_prod[fra_pkg::ACC_W-1:0];

    assign n_nneg_val = -{1'b0, r_nm};
    assign n_dneg_val = -r_dm;

    always_comb begin
        if (r_act >= fra_pkg::ACT_CLEAR) begin
            n_res_num = '0;
            n_res_den = '0;
        end else begin
            if (r_nneg) begin
                n_res_num = n_nneg_val[fra_pkg::NUM_W-1:0];
            end else if (r_nm[fra_pkg::MAG_W-1]) begin
                n_res_num = fra_pkg::NUM_MAX;
            end else begin
                n_res_num = r_nm;
            end
            if (r_dneg) begin
                n_res_den = n_dneg_val[fra_pkg::DEN_W-1:0];
            end else if (r_dm[fra_pkg::DEN_W-1]) begin
                n_res_den = fra_pkg::DEN_MAX;
            end else begin
                n_res_den = r_dm[fra_pkg::DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_act <= i_action;
            r_an  <= i_a_num;
            r_ad  <= i_a_den;
            r_bn  <= i_b_num;
            r_bd  <= i_b_den;
        end
        if (i_cmd.mul) begin
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_p3 <= n_p3;
        end
        if (i_cmd.form) begin
            r_nneg <= n_num[fra_pkg::PROD_W];
            r_dneg <= n_den[fra_pkg::PROD_W];
            r_nm   <= n_nabs[fra_pkg::MAG_W-1:0];
            r_dm   <= n_dabs[fra_pkg::MAG_W-1:0];
            r_k    <= KW'(2);
        end else if (i_cmd.apply) begin
            if (n_divisible) begin
                r_nm   <= n_nq;
                r_dm   <= n_dq;
                r_prod <= PW'(r_acc) * PW'(r_k);
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_res_num  <= n_res_num;
            r_res_den  <= n_res_den;
            r_res_prod <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= fra_pkg::ACC_ONE;
            r_prod_vld <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.apply && n_divisible;
            if (i_cmd.load_in && (i_action == fra_pkg::ACT_CLEAR)) begin
                r_acc <= fra_pkg::ACC_ONE;
            end else if (r_prod_vld) begin
                r_acc <= n_acc_sat;
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy    = r_o_valid && i_out_stall;
    assign o_out_valid       = r_o_valid;
    assign o_result_num      = r_res_num;
    assign o_result_den      = r_res_den;
    assign o_divisor_product = r_res_prod;

`ifndef ASSERT_OFF
    a_acc_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc != '0)
        else $error("Divisor product has become zero.");

    a_k_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_k >= KW'(2))
        else $error("Trial divisor below two during division.");

    a_prod_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prod_vld |-> $past(i_cmd.apply))
        else $error("Divisor product update without a reduction step.");
`endif

endmodule

// ===== design/fra_ctrl.sv =====
// Controller: sequences the cross-products, the bit-serial divisions and the
// reduction steps, and hands each finished result to the output register.
// Depends on fra_pkg.
module fra_ctrl #(
    parameter int REDUCE_STEPS = 500
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [fra_pkg::ACT_W-1:0] i_action,
    output logic                      o_in_stall,
    output fra_pkg::t_cmd             o_cmd,
    input  fra_pkg::t_sts             i_sts
);

    localparam int BW = $clog2(fra_pkg::MAG_W);
    localparam int SW = $clog2(REDUCE_STEPS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FORM,
        S_DIV,
        S_STEP,
        S_WRAP,
        S_FIN
    } t_state;

    t_state          r_state;
    logic [BW-1:0]   r_bit;
    logic [SW-1:0]   r_step;
    logic            n_accept;

    assign n_accept = (r_state == S_IDLE) && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        if (i_action inside {fra_pkg::ACT_ADD, fra_pkg::ACT_SUB,
                                             fra_pkg::ACT_MUL, fra_pkg::ACT_DIV}) begin
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_FORM;
                end
                S_FORM: begin
                    r_bit   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_bit == BW'(fra_pkg::MAG_W - 1)) begin
                        r_state <= S_STEP;
                    end else begin
                        r_bit <= r_bit + 1'b1;
                    end
                end
                S_STEP: begin
                    r_step <= r_step + 1'b1;
                    r_bit  <= '0;
                    if (r_step == SW'(REDUCE_STEPS - 1)) begin
                        r_state <= S_WRAP;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_WRAP: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!i_sts.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_in  = n_accept;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.form     = (r_state == S_FORM);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.apply    = (r_state == S_STEP);
        o_cmd.out_load = (r_state == S_FIN) && !i_sts.out_busy;
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef ASSERT_OFF
    a_step_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |=> (r_state == S_DIV || r_state == S_WRAP))
        else $error("Reduction step not followed by division or wrap-up.");

    a_wrap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRAP) |-> (r_step == SW'(REDUCE_STEPS)))
        else $error("Reduction finished with the wrong number of steps.");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_step < SW'(REDUCE_STEPS)))
        else $error("Division started beyond the last reduction step.");
`endif

endmodule

// ===== design/fraction_arith_trial_reduce.sv =====
// Fraction add, subtract, multiply and divide with reduction by bounded trial
// division. An arithmetic action runs the cross-products, forms the magnitudes
// and makes REDUCE_STEPS (default 500) reduction steps before its result goes
// to the output register; each step is one pass of the two bit-serial divider
// lanes, which yield both remainders and quotients at once, and then applies
// them. A clear action or an unused action code goes straight to the output
// register. Only one item is in work at a time, and a new input transfer is
// taken while the previous result still waits in the output register.
// Depends on fra_pkg, fra_ctrl and fra_datapath.
module fraction_arith_trial_reduce #(
    parameter int REDUCE_STEPS = 500
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [fra_pkg::ACT_W-1:0]          i_action,
    input  logic signed [fra_pkg::DATA_W-1:0]  i_a_num,
    input  logic signed [fra_pkg::DATA_W-1:0]  i_a_den,
    input  logic signed [fra_pkg::DATA_W-1:0]  i_b_num,
    input  logic signed [fra_pkg::DATA_W-1:0]  i_b_den,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [fra_pkg::NUM_W-1:0]   o_result_num,
    output logic signed [fra_pkg::DEN_W-1:0]   o_result_den,
    output logic [fra_pkg::ACC_W-1:0]          o_divisor_product
);

    fra_pkg::t_cmd w_cmd;
    fra_pkg::t_sts w_sts;

    fra_ctrl #(.REDUCE_STEPS(REDUCE_STEPS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    fra_datapath #(.REDUCE_STEPS(REDUCE_STEPS)) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_action          (i_action),
        .i_a_num           (i_a_num),
        .i_a_den           (i_a_den),
        .i_b_num           (i_b_num),
        .i_b_den           (i_b_den),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_result_num      (o_result_num),
        .o_result_den      (o_result_den),
        .o_divisor_product (o_divisor_product)
    );

endmodule
